>>> src/speaker_step_synth_filter_unit_macros.svh
// Assertion macros for the speaker step synthesis filter.
`ifndef SPEAKER_STEP_SYNTH_FILTER_UNIT_MACROS_SVH
`define SPEAKER_STEP_SYNTH_FILTER_UNIT_MACROS_SVH

// Checked while out of reset.
`define SSSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SSSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/sssf_pkg.sv
// Shared types, constants and impulse table of the speaker step synthesis filter.
package sssf_pkg;

  localparam int unsigned IMPULSE_TAPS = 7;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned TAP_W        = 12;
  localparam int unsigned WIN_W        = 16;
  localparam int unsigned FILT_W       = 32;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned LP_SHIFT_W   = 4;
  localparam int unsigned HP_SHIFT_W   = 5;
  localparam int unsigned CFG_DATA_W   = 5;

  localparam logic [LP_SHIFT_W-1:0] LP_SHIFT_RST = 4'd5;
  localparam logic [HP_SHIFT_W-1:0] HP_SHIFT_RST = 5'd12;

  typedef enum logic [1:0] {
    ACT_PLAIN     = 2'd0,
    ACT_TOGGLE    = 2'd1,
    ACT_POWER_OFF = 2'd2
  } action_e;

  typedef enum logic {
    CFG_LOWPASS_SHIFT  = 1'b0,
    CFG_HIGHPASS_SHIFT = 1'b1
  } cfg_reg_e;

  // Band-limited step impulses, one row per eighth-sample edge phase.
  localparam logic [TAP_W-1:0] IMPULSE_ROWS [8][IMPULSE_TAPS] = '{
    '{12'd161, 12'd1132, 12'd2616, 12'd2734, 12'd1322, 12'd224,  12'd3},
    '{12'd112, 12'd953,  12'd2473, 12'd2822, 12'd1522, 12'd302,  12'd8},
    '{12'd75,  12'd789,  12'd2309, 12'd2879, 12'd1727, 12'd397,  12'd16},
    '{12'd48,  12'd642,  12'd2128, 12'd2902, 12'd1932, 12'd511,  12'd29},
    '{12'd29,  12'd511,  12'd1932, 12'd2902, 12'd2128, 12'd642,  12'd48},
    '{12'd16,  12'd397,  12'd1727, 12'd2879, 12'd2309, 12'd789,  12'd75},
    '{12'd8,   12'd302,  12'd1522, 12'd2822, 12'd2473, 12'd953,  12'd112},
    '{12'd3,   12'd224,  12'd1322, 12'd2734, 12'd2616, 12'd1132, 12'd161}
  };

endpackage

>>> src/sssf_window_integ.sv
// Speaker level, pending impulse window and running-sum integrator stage.
module sssf_window_integ (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [1:0]                          action_i,
  input  logic [sssf_pkg::PHASE_W-1:0]        phase_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [sssf_pkg::WIN_W-1:0]   sample_o
);

  logic                              level_q, level_d;
  logic                              toggle;
  logic signed [sssf_pkg::WIN_W-1:0] win_q   [sssf_pkg::IMPULSE_TAPS];
  logic signed [sssf_pkg::WIN_W-1:0] win_nx  [sssf_pkg::IMPULSE_TAPS];
  logic signed [sssf_pkg::WIN_W-1:0] win_d   [sssf_pkg::IMPULSE_TAPS];
  logic signed [sssf_pkg::WIN_W-1:0] tap     [sssf_pkg::IMPULSE_TAPS];
  logic signed [sssf_pkg::WIN_W-1:0] sum_q, sum_d;
  logic                              valid_q;
  logic                              take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign sample_o = sum_q;

  always_comb begin
    case (sssf_pkg::action_e'(action_i))
      sssf_pkg::ACT_TOGGLE:    toggle = 1'b1;
      sssf_pkg::ACT_POWER_OFF: toggle = level_q;
      default:                 toggle = 1'b0;
    endcase
    level_d = level_q ^ toggle;
  end

  always_comb begin
    for (int i = 0; i < sssf_pkg::IMPULSE_TAPS; i++) begin
      tap[i] = signed'({{(sssf_pkg::WIN_W - sssf_pkg::TAP_W){1'b0}},
                        sssf_pkg::IMPULSE_ROWS[phase_i][i]});
      if (level_d) begin
        tap[i] = -tap[i];
      end
      win_nx[i] = toggle ? win_q[i] + tap[i] : win_q[i];
    end
    for (int i = 0; i < sssf_pkg::IMPULSE_TAPS - 1; i++) begin
      win_d[i] = win_nx[i+1];
    end
    win_d[sssf_pkg::IMPULSE_TAPS-1] = '0;
    // the running sum is only as wide as the window and wraps on overflow
    sum_d = sum_q + win_nx[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      level_q <= 1'b0;
      sum_q   <= '0;
      for (int i = 0; i < sssf_pkg::IMPULSE_TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        level_q <= level_d;
        sum_q   <= sum_d;
        for (int i = 0; i < sssf_pkg::IMPULSE_TAPS; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

endmodule

>>> src/sssf_one_pole.sv
// One-pole filter stage: state += (x - state) >>> shift, 16.16 fixed point.
module sssf_one_pole #(
  parameter int unsigned SHIFT_W = sssf_pkg::HP_SHIFT_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [SHIFT_W-1:0]                  shift_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [sssf_pkg::FILT_W-1:0]  x_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [sssf_pkg::FILT_W-1:0]  state_o
);

  logic signed [sssf_pkg::FILT_W-1:0] state_q, state_d;
  logic signed [sssf_pkg::FILT_W:0]   diff, step;
  logic                               valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign state_o = state_q;

  always_comb begin
    diff    = {x_i[sssf_pkg::FILT_W-1], x_i} - {state_q[sssf_pkg::FILT_W-1], state_q};
    step    = diff >>> shift_i;
    state_d = state_q + step[sssf_pkg::FILT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      state_q <= '0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      if (valid_i) begin
        state_q <= state_d;
      end
    end
  end

endmodule

>>> src/speaker_step_synth_filter_unit.sv
// Speaker step synthesis filter: one filtered 16-bit sample per request, one
// request per clock sustained while the output is not stalled. An accepted
// request passes four register stages (speaker level, impulse window and
// integrator; lowpass; highpass; difference and saturation) on its way to the
// output. Each stage updates its own feedback state as it takes a request,
// which is what sets the one-per-clock rate. Registers: index 0 lowpass
// shift (reset 5), index 1 highpass shift (reset 12); write them only while
// no request is in flight.
module speaker_step_synth_filter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [sssf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [1:0] action, [4:2] edge_phase
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata   // [15:0] sample_out
);

  logic [sssf_pkg::LP_SHIFT_W-1:0]   lp_shift_q;
  logic [sssf_pkg::HP_SHIFT_W-1:0]   hp_shift_q;

  logic                              win_valid, win_ready;
  logic signed [sssf_pkg::WIN_W-1:0] win_sample;
  logic signed [sssf_pkg::FILT_W-1:0] lp_x;
  logic                              lp_valid, lp_ready;
  logic signed [sssf_pkg::FILT_W-1:0] lp_state;
  logic                              hp_valid, hp_ready;
  logic signed [sssf_pkg::FILT_W-1:0] hp_state;
  logic signed [sssf_pkg::FILT_W-1:0] lp_c_q;

  logic                              out_ready;
  logic                              out_valid_q;
  logic [sssf_pkg::SAMPLE_W-1:0]     out_data_q, out_data_d;
  logic signed [sssf_pkg::FILT_W:0]  diff;
  logic signed [sssf_pkg::FILT_W-16:0] diff_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_shift_q <= sssf_pkg::LP_SHIFT_RST;
      hp_shift_q <= sssf_pkg::HP_SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (sssf_pkg::cfg_reg_e'(cfg_idx_i))
        sssf_pkg::CFG_LOWPASS_SHIFT:  lp_shift_q <= cfg_data_i[sssf_pkg::LP_SHIFT_W-1:0];
        sssf_pkg::CFG_HIGHPASS_SHIFT: hp_shift_q <= cfg_data_i[sssf_pkg::HP_SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  sssf_window_integ u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .action_i (s_axis_tdata[1:0]),
    .phase_i  (s_axis_tdata[4:2]),
    .valid_o  (win_valid),
    .ready_i  (win_ready),
    .sample_o (win_sample)
  );

  assign lp_x = {win_sample, 16'h0000};

  sssf_one_pole #(
    .SHIFT_W (sssf_pkg::LP_SHIFT_W)
  ) u_lowpass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (lp_shift_q),
    .valid_i (win_valid),
    .ready_o (win_ready),
    .x_i     (lp_x),
    .valid_o (lp_valid),
    .ready_i (lp_ready),
    .state_o (lp_state)
  );

  sssf_one_pole #(
    .SHIFT_W (sssf_pkg::HP_SHIFT_W)
  ) u_highpass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (hp_shift_q),
    .valid_i (lp_valid),
    .ready_o (lp_ready),
    .x_i     (lp_state),
    .valid_o (hp_valid),
    .ready_i (hp_ready),
    .state_o (hp_state)
  );

  // lowpass value travelling alongside the highpass stage
  always_ff @(posedge clk_i) begin
    if (lp_valid && lp_ready) begin
      lp_c_q <= lp_state;
    end
  end

  assign out_ready = !out_valid_q || m_axis_tready;
  assign hp_ready  = out_ready;

  always_comb begin
    diff    = {lp_c_q[sssf_pkg::FILT_W-1], lp_c_q} - {hp_state[sssf_pkg::FILT_W-1], hp_state};
    diff_hi = diff[sssf_pkg::FILT_W:16];
    if (diff_hi[16] == diff_hi[15]) begin
      out_data_d = diff_hi[15:0];
    end else if (diff_hi[16]) begin
      out_data_d = 16'h8000;
    end else begin
      out_data_d = 16'h7fff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= hp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && hp_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> src/sssf_port_check.sv
// Port-level checks for the speaker step synthesis filter, bound to the top level.
`include "speaker_step_synth_filter_unit_macros.svh"

module sssf_port_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `SSSF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output request dropped or changed while stalled")
  `SSSF_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")
  `SSSF_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a stalled output")
  `SSSF_ASSERT(a_idle_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

endmodule

bind speaker_step_synth_filter_unit sssf_port_check u_port_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sssf_tb_pkg.sv
// Sample scoreboard for the speaker step synthesis filter: predictor and expected queue.
`timescale 1ns / 100ps
package sssf_tb_pkg;
  import sssf_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint SAT_MAX = 32767;
  localparam longint SAT_MIN = -32768;

  class sample_tracker;
    bit                  level;
    shortint             window [IMPULSE_TAPS];
    int                  running_sum;
    int                  lowpass_acc;
    int                  highpass_acc;
    logic [LP_SHIFT_W-1:0] lp_shift;
    logic [HP_SHIFT_W-1:0] hp_shift;
    logic [SAMPLE_W-1:0] expected_samples [$];
    int                  mismatch_count;

    function new();
      level        = 1'b0;
      foreach (window[i]) window[i] = 16'sd0;
      running_sum  = 0;
      lowpass_acc  = 0;
      highpass_acc = 0;
      lp_shift     = LP_SHIFT_RST;
      hp_shift     = HP_SHIFT_RST;
      mismatch_count = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_LOWPASS_SHIFT) lp_shift = data[LP_SHIFT_W-1:0];
      else hp_shift = data[HP_SHIFT_W-1:0];
    endfunction

    function logic [SAMPLE_W-1:0] predict_sample(logic [1:0] action, logic [2:0] phase);
      int      i;
      int      tap;
      shortint integ;
      longint  diff;
      longint  d;
      if (action == ACT_TOGGLE || (action == ACT_POWER_OFF && level)) begin
        level = ~level;
        for (i = 0; i < IMPULSE_TAPS; i++) begin
          tap = int'(IMPULSE_ROWS[phase][i]);
          if (level) window[i] = shortint'(int'(window[i]) - tap);
          else window[i] = shortint'(int'(window[i]) + tap);
        end
      end
      running_sum = running_sum + int'(window[0]);
      integ = shortint'(running_sum);
      diff = longint'(integ) * 65536 - longint'(lowpass_acc);
      lowpass_acc = int'(longint'(lowpass_acc) + (diff >>> lp_shift));
      diff = longint'(lowpass_acc) - longint'(highpass_acc);
      highpass_acc = int'(longint'(highpass_acc) + (diff >>> hp_shift));
      d = (longint'(lowpass_acc) - longint'(highpass_acc)) >>> 16;
      if (d < SAT_MIN) d = SAT_MIN;
      if (d > SAT_MAX) d = SAT_MAX;
      for (i = 0; i + 1 < IMPULSE_TAPS; i++) window[i] = window[i+1];
      window[IMPULSE_TAPS-1] = 16'sd0;
      return d[SAMPLE_W-1:0];
    endfunction

    function void note_request(logic [1:0] action, logic [2:0] phase);
      expected_samples.push_back(predict_sample(action, phase));
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] actual);
      logic [SAMPLE_W-1:0] exp_sample;
      if (expected_samples.size() == 0) begin
        $error("sample_out: unexpected result, expected none, actual %0d", $signed(actual));
        mismatch_count++;
        return;
      end
      exp_sample = expected_samples.pop_front();
      if (exp_sample !== actual) begin
        $error("sample_out: expected %0d, actual %0d", $signed(exp_sample), $signed(actual));
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

>>> tb/tb_speaker_step_synth_filter_unit.sv
// Top-level testbench for the speaker step synthesis filter unit.
`timescale 1ns / 100ps
module tb_speaker_step_synth_filter_unit;
  import sssf_pkg::*;
  import sssf_tb_pkg::*;

  localparam int ITEMS_PER_PHASE = 180;
  localparam int PHASES          = 6;
  localparam int PRESSURE_PHASE  = 2;
  localparam int STEADY_PHASE    = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 20;
  localparam int IDLE_LIMIT      = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;

  bit steady_source = 1'b0;
  bit steady_sink   = 1'b0;
  bit hold_off      = 1'b0;

  sample_tracker tracker = new();

  speaker_step_synth_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int source_gap();
    if (steady_source || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  task automatic send_request(logic [1:0] action, logic [2:0] phase);
    int gap;
    s_axis_tdata  <= {3'b000, phase, action};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_request(action, phase);
    @(negedge clk_i);
    gap = source_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] lp_data, logic [CFG_DATA_W-1:0] hp_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOWPASS_SHIFT;
    cfg_data_i <= lp_data;
    @(posedge clk_i);
    tracker.set_reg(CFG_LOWPASS_SHIFT, lp_data);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HIGHPASS_SHIFT;
    cfg_data_i <= hp_data;
    @(posedge clk_i);
    tracker.set_reg(CFG_HIGHPASS_SHIFT, hp_data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    int         n;
    int         r;
    logic [1:0] action;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) action = ACT_PLAIN;
      else if (r < 75) action = ACT_TOGGLE;
      else if (r < 90) action = ACT_POWER_OFF;
      else action = ACT_UNUSED;
      send_request(action, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : stimulus
    int         p;
    int         ph;
    logic [3:0] lp;
    logic [4:0] hp;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(ACT_PLAIN, 3'd0);
    send_request(ACT_PLAIN, 3'd7);
    for (ph = 0; ph < 8; ph++) send_request(ACT_TOGGLE, 3'(ph));
    // power-off while low does nothing
    send_request(ACT_POWER_OFF, 3'd3);
    send_request(ACT_TOGGLE, 3'd5);
    send_request(ACT_POWER_OFF, 3'd2);
    send_request(ACT_UNUSED, 3'd7);
    repeat (4) send_request(ACT_PLAIN, 3'd4);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lp = 4'd1;  hp = 5'd1;  end
        1: begin lp = 4'd15; hp = 5'd20; end
        2: begin lp = 4'd0;  hp = 5'd0;  end
        3: begin lp = 4'd3;  hp = 5'd31; end
        4: begin lp = 4'd9;  hp = 5'd21; end
        default: begin
          lp = 4'($urandom_range(1, 15));
          hp = 5'($urandom_range(1, 20));
        end
      endcase
      configure({1'($urandom_range(0, 1)), lp}, hp);
      steady_source = (p == PRESSURE_PHASE) || (p == STEADY_PHASE);
      steady_sink   = (p == STEADY_PHASE);
      if (p == PRESSURE_PHASE) hold_off = 1'b1;
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len()) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_sample(m_axis_tdata);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sssf_pkg.sv
src/sssf_window_integ.sv
src/sssf_one_pole.sv
src/speaker_step_synth_filter_unit.sv
src/sssf_port_check.sv
tb/sssf_tb_pkg.sv
tb/tb_speaker_step_synth_filter_unit.sv
